// File: rtl/i2cm_pkg.sv
package i2cm_pkg;

   // Defaults handed to the top level parameters
   localparam int TIMER_WIDTH_DEFAULT = 16;
   localparam int QUEUE_DEPTH_DEFAULT = 4;

   // Register reset value: ticks per half SCL period
   localparam logic [15:0] HALF_PERIOD_RESET = 16'd500;

   // R/W bit appended to the address for a read
   localparam logic RW_READ = 1'b1;

   // Transfer outcome codes
   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_BUSY = 2'd1;
   localparam logic [1:0] ST_NACK = 2'd2;

   typedef enum logic [1:0] {
      CMD_TICK  = 2'd0,
      CMD_WRITE = 2'd1,
      CMD_READ  = 2'd2,
      CMD_LOAD  = 2'd3
   } cmd_type;

   // Bus engine phases: each bit slot has an edge, low and high part
   typedef enum logic [4:0] {
      PH_IDLE,
      PH_FINAL,
      PH_LOADWAIT,
      PH_TX_EDGE,
      PH_TX_LOW,
      PH_TX_HIGH,
      PH_TXACK_EDGE,
      PH_TXACK_LOW,
      PH_TXACK_HIGH,
      PH_RX_EDGE,
      PH_RX_LOW,
      PH_RX_HIGH,
      PH_MACK_EDGE,
      PH_MACK_LOW,
      PH_MACK_HIGH,
      PH_STOP_EDGE,
      PH_STOP_LOW,
      PH_STOP_HIGH
   } phase_type;

   typedef struct packed {
      cmd_type    command;
      logic [6:0] device_address;
      logic [7:0] byte_count;
      logic [7:0] write_byte;
      logic       scl_level;
      logic       sda_level;
   } req_type;

   typedef struct packed {
      logic       scl_release;
      logic       sda_release;
      logic [7:0] read_byte;
      logic       read_valid;
      logic       byte_request;
      logic       busy_res;
      logic       done_res;
      logic [1:0] status;
   } rsp_type;

   // Classified item as it travels from the front to the bus engine
   typedef struct packed {
      logic       begin_xfer;
      logic       read_xfer;
      logic       load_byte;
      logic [6:0] device_address;
      logic [7:0] byte_count;
      logic [7:0] write_byte;
      logic       scl_level;
      logic       sda_level;
   } entry_type;

endpackage

// File: rtl/i2cm_front.sv
module i2cm_front (
   input  logic               req_valid,
   input  i2cm_pkg::req_type  req_item,
   input  logic               queue_full,
   output logic               req_stall,
   output logic               push,
   output i2cm_pkg::entry_type push_entry
);
   import i2cm_pkg::*;

   // Accept whenever the queue has room
   assign req_stall = queue_full;
   assign push      = req_valid && !queue_full;

   // Classify the command so the engine sees flags only
   always_comb begin
      push_entry                = '0;
      push_entry.device_address = req_item.device_address;
      push_entry.byte_count     = req_item.byte_count;
      push_entry.write_byte     = req_item.write_byte;
      push_entry.scl_level      = req_item.scl_level;
      push_entry.sda_level      = req_item.sda_level;
      case (req_item.command)
         CMD_WRITE: begin
            push_entry.begin_xfer = 1'b1;
         end
         CMD_READ: begin
            push_entry.begin_xfer = 1'b1;
            push_entry.read_xfer  = 1'b1;
         end
         CMD_LOAD: begin
            push_entry.load_byte = 1'b1;
         end
         default: begin
         end
      endcase
   end

endmodule

// File: rtl/i2cm_queue.sv
module i2cm_queue #(
   parameter int DEPTH = i2cm_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  i2cm_pkg::entry_type push_entry,
   output logic                full,
   output logic                pop_valid,
   input  logic                pop_stall,
   output i2cm_pkg::entry_type pop_entry
);
   import i2cm_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   entry_type        mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             pop;

   assign full      = (count_ff == FULL_CNT);
   assign pop_valid = (count_ff != '0);
   assign pop       = pop_valid && !pop_stall;
   assign pop_entry = mem_ff[rd_ptr_ff];

   // Pointer and fill count bookkeeping
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_CNT)
      else $error("queue fill count beyond depth");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> count_ff == $past(count_ff) + CNT_W'(1))
      else $error("queue fill count did not follow a push");

endmodule

// File: rtl/i2cm_back.sv
module i2cm_back #(
   parameter int TIMER_WIDTH = i2cm_pkg::TIMER_WIDTH_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_we,
   input  logic [15:0]         csr_wdata,
   input  logic                pop_valid,
   output logic                pop_stall,
   input  i2cm_pkg::entry_type pop_entry,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output i2cm_pkg::rsp_type   rsp_item
);
   import i2cm_pkg::*;

   logic [15:0]            half_ff;
   phase_type              phase_ff, phase_in;
   logic [3:0]             bit_cnt_ff, bit_cnt_in;
   logic [7:0]             bytes_ff, bytes_in;
   logic [7:0]             shift_ff, shift_in;
   logic [TIMER_WIDTH-1:0] timer_ff, timer_in;
   logic [1:0]             status_ff, status_in;
   logic                   reading_ff, reading_in;
   logic [7:0]             held_byte_ff, held_byte_in;
   logic                   held_valid_ff, held_valid_in;
   logic                   scl_ff, scl_in;
   logic                   sda_ff, sda_in;
   logic                   rsp_valid_ff;
   rsp_type                rsp_item_ff, rsp_item_in;
   logic                   take;
   logic                   expired;
   logic                   done;
   logic                   rvalid;
   logic [7:0]             rbyte;
   logic [TIMER_WIDTH-1:0] reload;

   assign reload    = TIMER_WIDTH'(half_ff);
   assign take      = pop_valid && (!rsp_valid_ff || !rsp_stall);
   assign pop_stall = !(!rsp_valid_ff || !rsp_stall);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   // One tick of the bus engine
   always_comb begin
      phase_in      = phase_ff;
      bit_cnt_in    = bit_cnt_ff;
      bytes_in      = bytes_ff;
      shift_in      = shift_ff;
      timer_in      = timer_ff;
      status_in     = status_ff;
      reading_in    = reading_ff;
      held_byte_in  = held_byte_ff;
      held_valid_in = held_valid_ff;
      scl_in        = scl_ff;
      sda_in        = sda_ff;
      expired       = 1'b0;
      done          = 1'b0;
      rvalid        = 1'b0;
      rbyte         = '0;

      // Holding register load, ahead of the engine
      if (pop_entry.load_byte) begin
         held_byte_in  = pop_entry.write_byte;
         held_valid_in = 1'b1;
      end

      if (phase_ff == PH_IDLE) begin
         // Start condition only on a free bus
         if (pop_entry.begin_xfer) begin
            if (pop_entry.scl_level && pop_entry.sda_level) begin
               reading_in = pop_entry.read_xfer;
               shift_in   = {pop_entry.device_address,
                             pop_entry.read_xfer ? RW_READ : 1'b0};
               bytes_in   = pop_entry.byte_count;
               bit_cnt_in = '0;
               status_in  = ST_OK;
               scl_in     = 1'b1;
               sda_in     = 1'b0;
               timer_in   = reload;
               phase_in   = PH_TX_EDGE;
            end else begin
               status_in = ST_BUSY;
               done      = 1'b1;
            end
         end
      end else begin
         if (timer_ff != '0) begin
            timer_in = timer_ff - TIMER_WIDTH'(1);
         end
         expired = (timer_in == '0);

         // Next write byte arrives from the holding register
         if (phase_in == PH_LOADWAIT && held_valid_in) begin
            shift_in      = held_byte_in;
            held_valid_in = 1'b0;
            bytes_in      = bytes_in - 8'd1;
            bit_cnt_in    = '0;
            phase_in      = PH_TX_EDGE;
         end

         case (phase_in)
            PH_FINAL: begin
               if (expired) begin
                  scl_in   = 1'b1;
                  sda_in   = 1'b1;
                  phase_in = PH_IDLE;
                  done     = 1'b1;
               end
            end
            // Falling SCL edge: pull SCL low and set up SDA
            PH_TX_EDGE, PH_TXACK_EDGE, PH_RX_EDGE, PH_MACK_EDGE, PH_STOP_EDGE: begin
               if (expired) begin
                  scl_in   = 1'b0;
                  timer_in = reload;
                  case (phase_in)
                     PH_TX_EDGE: begin
                        sda_in   = shift_in[7];
                        phase_in = PH_TX_LOW;
                     end
                     PH_TXACK_EDGE: begin
                        sda_in   = 1'b1;
                        phase_in = PH_TXACK_LOW;
                     end
                     PH_RX_EDGE: begin
                        sda_in   = 1'b1;
                        phase_in = PH_RX_LOW;
                     end
                     PH_MACK_EDGE: begin
                        sda_in   = (bytes_in == '0);
                        phase_in = PH_MACK_LOW;
                     end
                     default: begin
                        sda_in   = 1'b0;
                        phase_in = PH_STOP_LOW;
                     end
                  endcase
               end
            end
            // Low half over: release SCL
            PH_TX_LOW, PH_TXACK_LOW, PH_RX_LOW, PH_MACK_LOW, PH_STOP_LOW: begin
               if (expired) begin
                  scl_in   = 1'b1;
                  timer_in = reload;
                  case (phase_in)
                     PH_TX_LOW:    phase_in = PH_TX_HIGH;
                     PH_TXACK_LOW: phase_in = PH_TXACK_HIGH;
                     PH_RX_LOW:    phase_in = PH_RX_HIGH;
                     PH_MACK_LOW:  phase_in = PH_MACK_HIGH;
                     default:      phase_in = PH_STOP_HIGH;
                  endcase
               end
            end
            // High half: wait out clock stretching, then sample
            PH_TX_HIGH: begin
               if (pop_entry.scl_level) begin
                  if (pop_entry.sda_level != shift_in[7]) begin
                     // arbitration lost
                     status_in = ST_BUSY;
                     if (reading_ff) begin
                        phase_in = PH_STOP_EDGE;
                     end else begin
                        scl_in   = 1'b1;
                        sda_in   = 1'b1;
                        phase_in = PH_IDLE;
                        done     = 1'b1;
                     end
                  end else begin
                     shift_in   = {shift_in[6:0], 1'b0};
                     bit_cnt_in = bit_cnt_in + 4'd1;
                     phase_in   = (bit_cnt_in >= 4'd8) ? PH_TXACK_EDGE : PH_TX_EDGE;
                  end
               end
            end
            PH_TXACK_HIGH: begin
               if (pop_entry.scl_level) begin
                  if (pop_entry.sda_level) begin
                     // slave NACK
                     status_in = ST_NACK;
                     if (reading_ff) begin
                        phase_in = PH_STOP_EDGE;
                     end else begin
                        scl_in   = 1'b1;
                        sda_in   = 1'b1;
                        phase_in = PH_IDLE;
                        done     = 1'b1;
                     end
                  end else if (bytes_in == '0) begin
                     phase_in = PH_STOP_EDGE;
                  end else if (reading_ff) begin
                     bit_cnt_in = '0;
                     phase_in   = PH_RX_EDGE;
                  end else begin
                     phase_in = PH_LOADWAIT;
                  end
               end
            end
            PH_RX_HIGH: begin
               if (pop_entry.scl_level) begin
                  shift_in   = {shift_in[6:0], pop_entry.sda_level};
                  bit_cnt_in = bit_cnt_in + 4'd1;
                  if (bit_cnt_in >= 4'd8) begin
                     rvalid   = 1'b1;
                     rbyte    = shift_in;
                     bytes_in = bytes_in - 8'd1;
                     phase_in = PH_MACK_EDGE;
                  end else begin
                     phase_in = PH_RX_EDGE;
                  end
               end
            end
            PH_MACK_HIGH: begin
               if (pop_entry.scl_level) begin
                  bit_cnt_in = '0;
                  phase_in   = (bytes_in != '0) ? PH_RX_EDGE : PH_STOP_EDGE;
               end
            end
            PH_STOP_HIGH: begin
               if (pop_entry.scl_level) begin
                  phase_in = PH_FINAL;
               end
            end
            default: begin
            end
         endcase
      end

      // Result item from the state after the tick
      rsp_item_in.scl_release  = scl_in;
      rsp_item_in.sda_release  = sda_in;
      rsp_item_in.read_byte    = rbyte;
      rsp_item_in.read_valid   = rvalid;
      rsp_item_in.byte_request = (phase_in != PH_IDLE) && !reading_in &&
                                 (bytes_in != '0) && !held_valid_in;
      rsp_item_in.busy_res     = (phase_in != PH_IDLE);
      rsp_item_in.done_res     = done;
      rsp_item_in.status       = status_in;
   end

   // Engine state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         bit_cnt_ff    <= '0;
         bytes_ff      <= '0;
         shift_ff      <= '0;
         timer_ff      <= '0;
         status_ff     <= ST_OK;
         reading_ff    <= 1'b0;
         held_valid_ff <= 1'b0;
         scl_ff        <= 1'b1;
         sda_ff        <= 1'b1;
      end else if (take) begin
         phase_ff      <= phase_in;
         bit_cnt_ff    <= bit_cnt_in;
         bytes_ff      <= bytes_in;
         shift_ff      <= shift_in;
         timer_ff      <= timer_in;
         status_ff     <= status_in;
         reading_ff    <= reading_in;
         held_valid_ff <= held_valid_in;
         scl_ff        <= scl_in;
         sda_ff        <= sda_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         held_byte_ff <= held_byte_in;
      end
   end

   // Half period register
   always_ff @(posedge clock) begin
      if (reset) begin
         half_ff <= HALF_PERIOD_RESET;
      end else if (csr_we) begin
         half_ff <= csr_wdata;
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (take) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         rsp_item_ff <= rsp_item_in;
      end
   end

   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_item_ff.done_res |-> !rsp_item_ff.busy_res)
      else $error("transfer end reported while still busy");

   a_read_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_item_ff.read_valid |->
         rsp_item_ff.busy_res && !rsp_item_ff.done_res)
      else $error("received byte outside a running transfer");

   a_bit_count: assert property (@(posedge clock) disable iff (reset)
      bit_cnt_ff <= 4'd8)
      else $error("bit counter ran past a byte");

   a_read_no_load: assert property (@(posedge clock) disable iff (reset)
      !(reading_ff && phase_ff == PH_LOADWAIT))
      else $error("read transfer waiting for a write byte");

endmodule

// File: rtl/i2c_master_byte_transfer.sv
// Result path: an accepted item is written into the queue, then one engine tick takes it into the
// output register, where its result is offered; a stall on the result side delays it.
// Throughput: one item per cycle while the queue has room; the bus engine executes one tick per cycle
// unless the output is stalled, and the QUEUE_DEPTH entry queue absorbs stalls on the result side.
// Reset (synchronous, active high): engine idle, SCL and SDA released, status success,
// holding register empty, queue empty, half period 500 ticks.
module i2c_master_byte_transfer #(
   parameter int TIMER_WIDTH = i2cm_pkg::TIMER_WIDTH_DEFAULT,
   parameter int QUEUE_DEPTH = i2cm_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_we,
   input  logic [15:0]       csr_wdata,
   input  logic              req_valid,
   output logic              req_stall,
   input  i2cm_pkg::req_type req_item,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output i2cm_pkg::rsp_type rsp_item
);
   import i2cm_pkg::*;

   logic      queue_full;
   logic      push;
   entry_type push_entry;
   logic      pop_valid;
   logic      pop_stall;
   entry_type pop_entry;

   // Front: accept and classify items
   i2cm_front u_front (
      .req_valid  (req_valid),
      .req_item   (req_item),
      .queue_full (queue_full),
      .req_stall  (req_stall),
      .push       (push),
      .push_entry (push_entry)
   );

   // Queue between front and engine
   i2cm_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop_valid  (pop_valid),
      .pop_stall  (pop_stall),
      .pop_entry  (pop_entry)
   );

   // Back: bus engine and output register
   i2cm_back #(
      .TIMER_WIDTH (TIMER_WIDTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .pop_valid (pop_valid),
      .pop_stall (pop_stall),
      .pop_entry (pop_entry),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

endmodule
